// File: rtl/vote_confidence_accumulator_unit_assert.svh
// ----------------------------------------------------------------------------
// Vote confidence accumulator assertion macros
// Concurrent assertion wrappers used by the accumulator RTL; they compile
// away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef VOTE_CONFIDENCE_ACCUMULATOR_UNIT_ASSERT_SVH
`define VOTE_CONFIDENCE_ACCUMULATOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Check prop on every rising edge of ck outside of reset.
`define VCA_ASSERT(lbl, ck, rn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (prop)) else $error(msg);

// Check that cons holds in the same cycle as ante.
`define VCA_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
    `VCA_ASSERT(lbl, ck, rn, (ante) |-> (cons), msg)

// Check that cons holds in the cycle after ante.
`define VCA_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    `VCA_ASSERT(lbl, ck, rn, (ante) |=> (cons), msg)

`else

`define VCA_ASSERT(lbl, ck, rn, prop, msg)
`define VCA_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg)
`define VCA_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg)

`endif

`endif

// File: rtl/vca_pkg.sv
// ----------------------------------------------------------------------------
// Vote confidence accumulator package
// Widths, codes and shared types of the per-slot confidence table.
// ----------------------------------------------------------------------------
package vca_pkg;

    localparam int SLOTS    = 256;
    localparam int SLOT_W   = 8;
    localparam int VOTE_W   = 11;
    localparam int STREAK_W = 8;
    localparam int ROUNDS_W = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [VOTE_W-1:0] MAX_COMMITTEE = VOTE_W'(1024);

    localparam logic [1:0] VERDICT_UNDECIDED = 2'd0;
    localparam logic [1:0] VERDICT_ACCEPT    = 2'd1;
    localparam logic [1:0] VERDICT_REJECT    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_COMMITTEE_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VOTE_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CONFIRM_ROUNDS = 2'd2;

    localparam logic [VOTE_W-1:0]   RESET_COMMITTEE_SIZE = VOTE_W'(20);
    localparam logic [VOTE_W-1:0]   RESET_VOTE_THRESHOLD = VOTE_W'(14);
    localparam logic [ROUNDS_W-1:0] RESET_CONFIRM_ROUNDS = ROUNDS_W'(20);

    typedef struct packed {
        logic [STREAK_W-1:0] streak;
        logic                pref;
        logic                has_pref;
        logic                decided;
        logic [1:0]          outcome;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic [VOTE_W-1:0]   committee_size;
        logic [VOTE_W-1:0]   vote_threshold;
        logic [ROUNDS_W-1:0] confirm_rounds;
    } cfg_t;

endpackage

// File: rtl/vca_table.sv
// ----------------------------------------------------------------------------
// Vote confidence slot table
// Synchronous slot memory with registered read data, per-entry valid bits
// that make unwritten entries read as zero, and same-edge write bypass.
// ----------------------------------------------------------------------------
module vca_table (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rd_en,
    input  logic [vca_pkg::SLOT_W-1:0]  rd_addr,
    output vca_pkg::entry_t             rd_data,
    input  logic                        wr_en,
    input  logic [vca_pkg::SLOT_W-1:0]  wr_addr,
    input  vca_pkg::entry_t             wr_data
);
    import vca_pkg::*;

    logic [ENTRY_W-1:0] mem [SLOTS];
    logic [SLOTS-1:0]   valid_reg;
    logic [ENTRY_W-1:0] rd_q_reg;
    logic               rd_valid_reg;
    logic               rd_hit_reg;
    entry_t             rd_byp_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q_reg   <= mem[rd_addr];
            rd_byp_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            rd_hit_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
                rd_hit_reg   <= wr_en && (wr_addr == rd_addr);
            end
        end
    end

    always_comb
    begin
        if (rd_hit_reg)
        begin
            rd_data = rd_byp_reg;
        end
        else if (rd_valid_reg)
        begin
            rd_data = entry_t'(rd_q_reg);
        end
        else
        begin
            rd_data = '0;
        end
    end

endmodule

// File: rtl/vca_update.sv
// ----------------------------------------------------------------------------
// Vote confidence round update
// Clamps one round's votes and computes the slot's next streak, preference
// and verdict from its current table entry.
// ----------------------------------------------------------------------------
module vca_update (
    input  vca_pkg::cfg_t               cfg,
    input  logic [vca_pkg::VOTE_W-1:0]  yes_votes,
    input  logic [vca_pkg::VOTE_W-1:0]  total_votes,
    input  vca_pkg::entry_t             cur,
    output vca_pkg::entry_t             nxt
);
    import vca_pkg::*;

    logic [VOTE_W-1:0] k;
    logic [VOTE_W-1:0] tot;
    logic [VOTE_W-1:0] yes;
    logic [VOTE_W-1:0] no;
    logic              yes_wins;
    logic              decisive;

    always_comb
    begin
        k   = (cfg.committee_size > MAX_COMMITTEE) ? MAX_COMMITTEE : cfg.committee_size;
        tot = (total_votes > k) ? k : total_votes;
        yes = (yes_votes > tot) ? tot : yes_votes;
        no  = tot - yes;
        yes_wins = (yes >= cfg.vote_threshold);
        decisive = yes_wins || (no >= cfg.vote_threshold);

        nxt = cur;
        if (!cur.decided && (tot != '0))
        begin
            if (decisive)
            begin
                if (cur.has_pref && (cur.pref == yes_wins))
                begin
                    if (cur.streak != '1)
                    begin
                        nxt.streak = cur.streak + STREAK_W'(1);
                    end
                end
                else
                begin
                    nxt.streak = STREAK_W'(1);
                end
                nxt.pref     = yes_wins;
                nxt.has_pref = 1'b1;
            end
            else
            begin
                nxt.streak = '0;
            end

            if (nxt.streak >= cfg.confirm_rounds)
            begin
                nxt.decided = 1'b1;
                nxt.outcome = nxt.pref ? VERDICT_ACCEPT : VERDICT_REJECT;
            end
        end
    end

endmodule

// File: rtl/vote_confidence_accumulator_unit.sv
// ----------------------------------------------------------------------------
// Vote confidence accumulator
// Per-slot consecutive-confirmation counter with latched accept or reject.
// ----------------------------------------------------------------------------
// Usage:
//   s_tdata carries one voting round (slot, yes count, total count). Every
//   accepted round returns one result on m_tdata: the slot's verdict and
//   confidence after the round, in order of acceptance.
//   cfg_valid/cfg_index/cfg_data write committee size, vote threshold and
//   confirm rounds; cfg_ready is always high. Write only while idle.
// Pipeline: the round is accepted and the table read is registered at the
//   same edge; the result register loads when the read stage advances, which
//   a held result can delay, and m_tvalid then rises.
// Throughput: one round per cycle while results are taken. The slot table
//   does one read and one write-back per cycle; a write at the same edge as
//   a read of that slot is bypassed into the read data, so rounds for one
//   slot may follow each other back to back.
// Reset: the configuration returns to 20 / 14 / 20 and every slot reads as
//   zero through per-slot valid bits; no clearing pass, rounds are taken
//   from the first cycle after reset.
// Stall: while m_tready is low the finished result holds, one more round
//   waits in the read stage, and s_tready drops until the result is taken.
// ----------------------------------------------------------------------------
`include "vote_confidence_accumulator_unit_assert.svh"

module vote_confidence_accumulator_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [7:0] item_slot, [18:8] yes_votes, [29:19] total_votes, [31:30] zero
    input  logic [31:0]                    s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [1:0] verdict, [9:2] confidence, [15:10] zero
    output logic [15:0]                    m_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [vca_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [vca_pkg::VOTE_W-1:0]     cfg_data
);
    import vca_pkg::*;

    cfg_t                cfg_reg;
    logic                s1_valid_reg;
    logic [SLOT_W-1:0]   s1_slot_reg;
    logic [VOTE_W-1:0]   s1_yes_reg;
    logic [VOTE_W-1:0]   s1_total_reg;
    logic                out_valid_reg;
    logic [1:0]          out_verdict_reg;
    logic [STREAK_W-1:0] out_conf_reg;

    logic                in_fire;
    logic                s1_adv;
    entry_t              cur;
    entry_t              nxt;

    assign cfg_ready = 1'b1;
    assign s1_adv    = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !s1_valid_reg || s1_adv;
    assign in_fire   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.committee_size <= RESET_COMMITTEE_SIZE;
            cfg_reg.vote_threshold <= RESET_VOTE_THRESHOLD;
            cfg_reg.confirm_rounds <= RESET_CONFIRM_ROUNDS;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_COMMITTEE_SIZE: cfg_reg.committee_size <= cfg_data;
                REG_VOTE_THRESHOLD: cfg_reg.vote_threshold <= cfg_data;
                REG_CONFIRM_ROUNDS: cfg_reg.confirm_rounds <= cfg_data[ROUNDS_W-1:0];
                default: ;
            endcase
        end
    end

    vca_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_fire),
        .rd_addr (s_tdata[SLOT_W-1:0]),
        .rd_data (cur),
        .wr_en   (s1_adv),
        .wr_addr (s1_slot_reg),
        .wr_data (nxt)
    );

    vca_update u_update (
        .cfg         (cfg_reg),
        .yes_votes   (s1_yes_reg),
        .total_votes (s1_total_reg),
        .cur         (cur),
        .nxt         (nxt)
    );

    // advance the read stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_slot_reg  <= s_tdata[7:0];
            s1_yes_reg   <= s_tdata[18:8];
            s1_total_reg <= s_tdata[29:19];
        end
    end

    // hold the result until the transaction completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_verdict_reg <= nxt.outcome;
            out_conf_reg    <= nxt.streak;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_conf_reg, out_verdict_reg};

    `VCA_ASSERT_NEXT(a_result_loaded, clk, rst_n, s1_adv, m_tvalid, "result register not loaded")
    `VCA_ASSERT_IMPL(a_decided_frozen, clk, rst_n, s1_adv && cur.decided, nxt == cur, "decided slot changed")
    `VCA_ASSERT_IMPL(a_decided_verdict, clk, rst_n, s1_adv && nxt.decided, nxt.outcome != VERDICT_UNDECIDED, "decided slot without verdict")
    `VCA_ASSERT_IMPL(a_no_overrun, clk, rst_n, in_fire && s1_valid_reg, s1_adv, "read stage overwritten")

endmodule

// File: test/vote_tally_checker.sv
// ----------------------------------------------------------------------------
// Vote tally checker
// Watches the round, result and register channels of the vote confidence
// accumulator, keeps its own per-slot streak table, predicts the verdict and
// confidence of every accepted round and compares them with the results in
// order of acceptance.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module vote_tally_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [31:0]                   s_tdata,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [15:0]                   m_tdata,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [vca_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [vca_pkg::VOTE_W-1:0]    cfg_data,
    output int                            failures,
    output int                            outstanding,
    output int                            rounds_seen,
    output int                            accepts_seen,
    output int                            rejects_seen
);
    import vca_pkg::*;

    typedef struct packed {
        logic [STREAK_W-1:0] streak;
        logic                side_accept;
        logic                has_side;
        logic                decided;
        logic [1:0]          verdict;
    } slot_state_t;

    typedef struct packed {
        logic [SLOT_W-1:0]   slot;
        logic [1:0]          verdict;
        logic [STREAK_W-1:0] confidence;
    } slot_outcome_t;

    logic [VOTE_W-1:0]   committee_size;
    logic [VOTE_W-1:0]   vote_threshold;
    logic [ROUNDS_W-1:0] confirm_rounds;
    slot_state_t         slot_table [SLOTS];
    slot_outcome_t       expected_outcomes [$];
    slot_outcome_t       wanted;
    int                  err_count;
    int                  report_count;
    int                  round_count;
    int                  accept_count;
    int                  reject_count;

    function automatic slot_outcome_t tally_round(input logic [SLOT_W-1:0] slot,
                                                  input logic [VOTE_W-1:0] yes_in,
                                                  input logic [VOTE_W-1:0] total_in);
        slot_state_t       e;
        slot_outcome_t     r;
        logic [VOTE_W-1:0] k;
        logic [VOTE_W-1:0] yes_c;
        logic [VOTE_W-1:0] total_c;
        logic              decisive;
        logic              side;
        e = slot_table[slot];
        k = (committee_size > MAX_COMMITTEE) ? MAX_COMMITTEE : committee_size;
        decisive = 1'b0;
        side = 1'b0;
        if (!e.decided)
        begin
            total_c = (total_in > k) ? k : total_in;
            if (total_c != '0)
            begin
                yes_c = (yes_in > total_c) ? total_c : yes_in;
                if (yes_c >= vote_threshold)
                begin
                    decisive = 1'b1;
                    side = 1'b1;
                end
                else if (total_c - yes_c >= vote_threshold)
                begin
                    decisive = 1'b1;
                end
                if (decisive)
                begin
                    if (e.has_side && e.side_accept == side)
                    begin
                        if (e.streak != '1)
                            e.streak = e.streak + 1'b1;
                    end
                    else
                    begin
                        e.streak = STREAK_W'(1);
                    end
                    e.side_accept = side;
                    e.has_side = 1'b1;
                end
                else
                begin
                    e.streak = '0;
                end
                if (e.streak >= confirm_rounds)
                begin
                    e.decided = 1'b1;
                    e.verdict = e.side_accept ? VERDICT_ACCEPT : VERDICT_REJECT;
                end
            end
        end
        slot_table[slot] = e;
        r.slot = slot;
        r.verdict = e.verdict;
        r.confidence = e.streak;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            committee_size = RESET_COMMITTEE_SIZE;
            vote_threshold = RESET_VOTE_THRESHOLD;
            confirm_rounds = RESET_CONFIRM_ROUNDS;
            for (int i = 0; i < SLOTS; i++)
                slot_table[i] = '0;
            expected_outcomes.delete();
            err_count = 0;
            report_count = 0;
            round_count = 0;
            accept_count = 0;
            reject_count = 0;
            failures <= 0;
            outstanding <= 0;
            rounds_seen <= 0;
            accepts_seen <= 0;
            rejects_seen <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_COMMITTEE_SIZE: committee_size = cfg_data;
                    REG_VOTE_THRESHOLD: vote_threshold = cfg_data;
                    REG_CONFIRM_ROUNDS: confirm_rounds = cfg_data[ROUNDS_W-1:0];
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready)
            begin
                expected_outcomes.push_back(tally_round(s_tdata[7:0], s_tdata[18:8],
                                                        s_tdata[29:19]));
                round_count++;
            end

            if (m_tvalid && m_tready)
            begin
                if (m_tdata[1:0] == VERDICT_ACCEPT)
                    accept_count++;
                if (m_tdata[1:0] == VERDICT_REJECT)
                    reject_count++;
                if (expected_outcomes.size() == 0)
                begin
                    err_count++;
                    if (report_count < 10)
                    begin
                        report_count++;
                        $display("%0t: result with nothing pending: verdict %0d confidence %0d",
                                 $realtime, m_tdata[1:0], m_tdata[9:2]);
                    end
                end
                else
                begin
                    wanted = expected_outcomes.pop_front();
                    if (m_tdata[1:0] !== wanted.verdict)
                    begin
                        err_count++;
                        if (report_count < 10)
                        begin
                            report_count++;
                            $display("%0t: slot %0d verdict: expected %0d, got %0d",
                                     $realtime, wanted.slot, wanted.verdict, m_tdata[1:0]);
                        end
                    end
                    if (m_tdata[9:2] !== wanted.confidence)
                    begin
                        err_count++;
                        if (report_count < 10)
                        begin
                            report_count++;
                            $display("%0t: slot %0d confidence: expected %0d, got %0d",
                                     $realtime, wanted.slot, wanted.confidence,
                                     m_tdata[9:2]);
                        end
                    end
                end
            end

            failures <= err_count;
            outstanding <= expected_outcomes.size();
            rounds_seen <= round_count;
            accepts_seen <= accept_count;
            rejects_seen <= reject_count;
        end
    end

endmodule

// File: test/tb_vote_confidence_accumulator_unit.sv
// ----------------------------------------------------------------------------
// Vote confidence accumulator testbench
// Drives voting rounds and register writes into the accumulator under a
// series of committee, threshold and confirmation settings, with random
// gaps on both streams, a long result hold-off and full drains. A separate
// checker predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_vote_confidence_accumulator_unit;

    import vca_pkg::*;

    typedef enum int {ROUND_YES, ROUND_NO, ROUND_WEAK, ROUND_QUERY} round_kind_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [31:0]          s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [15:0]          m_tdata;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [VOTE_W-1:0]    cfg_data;

    int failures;
    int outstanding;
    int rounds_seen;
    int accepts_seen;
    int rejects_seen;

    int                tx_idle_pct;
    int                rx_stall_pct;
    int                holdoff_seq;
    int                sent_total;
    int                settings_used;
    logic [VOTE_W-1:0] cur_committee;
    logic [VOTE_W-1:0] cur_threshold;
    logic              side_of_slot [SLOTS];

    vote_confidence_accumulator_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    vote_tally_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .failures     (failures),
        .outstanding  (outstanding),
        .rounds_seen  (rounds_seen),
        .accepts_seen (accepts_seen),
        .rejects_seen (rejects_seen)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #5ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    // receiver: random stalls, long hold-off on request
    initial
    begin
        int seen_seq;
        int hold_left;
        seen_seq = 0;
        hold_left = 0;
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (holdoff_seq != seen_seq)
            begin
                seen_seq = holdoff_seq;
                hold_left = 40;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    task automatic send_round(input logic [SLOT_W-1:0] slot, input logic [VOTE_W-1:0] yes,
                              input logic [VOTE_W-1:0] total);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, total, yes, slot};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent_total++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VOTE_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic apply_settings(input logic [VOTE_W-1:0] committee,
                                  input logic [VOTE_W-1:0] threshold,
                                  input logic [VOTE_W-1:0] rounds);
        drain_results();
        write_reg(REG_COMMITTEE_SIZE, committee);
        write_reg(REG_VOTE_THRESHOLD, threshold);
        write_reg(REG_CONFIRM_ROUNDS, rounds);
        cfg_valid <= 1'b0;
        cur_committee = committee;
        cur_threshold = threshold;
        settings_used++;
    endtask

    task automatic build_round(input round_kind_t kind, output logic [VOTE_W-1:0] yes,
                               output logic [VOTE_W-1:0] total);
        int k;
        int lo;
        int t;
        int y;
        k = (cur_committee > 1024) ? 1024 : cur_committee;
        lo = (cur_threshold == 0) ? 1 : cur_threshold;
        t = $urandom_range(2047);
        y = $urandom_range(2047);
        case (kind)
            ROUND_YES:
                if (k > 0 && cur_threshold <= k)
                begin
                    t = $urandom_range(k, lo);
                    y = $urandom_range(t, cur_threshold);
                end
            ROUND_NO:
                if (k > 0 && cur_threshold <= k)
                begin
                    t = $urandom_range(k, lo);
                    y = t - $urandom_range(t, cur_threshold);
                end
            ROUND_WEAK:
                if (k > 0)
                begin
                    t = $urandom_range(k, 1);
                    y = $urandom_range(t);
                end
            default:
                t = 0;
        endcase
        if (kind != ROUND_QUERY && t < 2047 && $urandom_range(7) == 0)
            t = $urandom_range(2047, t);
        yes = VOTE_W'(y);
        total = VOTE_W'(t);
    endtask

    task automatic run_phase(input int base, input int n_hot, input int n_items,
                             input int noise_pct, input int flip_pct);
        logic [SLOT_W-1:0] slot;
        logic [VOTE_W-1:0] yes;
        logic [VOTE_W-1:0] total;
        round_kind_t       kind;
        int                mode;
        int                r;
        for (int i = 0; i < n_hot; i++)
            side_of_slot[(base + i) % SLOTS] = 1'($urandom_range(1));
        for (int i = 0; i < n_items; i++)
        begin
            mode = (sent_total / 40) % 4;
            tx_idle_pct = (mode == 1) ? 55 : (mode == 3) ? 21 : 0;
            rx_stall_pct <= (mode == 2) ? 55 : (mode == 3) ? 21 : 0;
            if (n_items >= 20 && i == n_items / 2)
                holdoff_seq <= holdoff_seq + 1;
            if (n_items >= 20 && i == (3 * n_items) / 4)
                drain_results();
            if ($urandom_range(99) < noise_pct)
            begin
                slot = SLOT_W'($urandom_range(SLOTS - 1));
                yes = VOTE_W'($urandom_range(2047));
                total = ($urandom_range(3) == 0) ? '0 : VOTE_W'($urandom_range(2047));
            end
            else
            begin
                slot = SLOT_W'((base + $urandom_range(n_hot - 1)) % SLOTS);
                kind = side_of_slot[slot] ? ROUND_YES : ROUND_NO;
                if ($urandom_range(99) < flip_pct)
                begin
                    r = $urandom_range(2);
                    kind = (r == 0) ? ROUND_WEAK : (r == 1) ? ROUND_QUERY :
                           side_of_slot[slot] ? ROUND_NO : ROUND_YES;
                end
                build_round(kind, yes, total);
            end
            send_round(slot, yes, total);
        end
    endtask

    initial
    begin
        int waited;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        holdoff_seq = 0;
        sent_total = 0;
        settings_used = 1;
        cur_committee = RESET_COMMITTEE_SIZE;
        cur_threshold = RESET_VOTE_THRESHOLD;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: clamping, switching, inconclusive and query rounds
        send_round(8'd0, 11'd0, 11'd0);
        send_round(8'd255, 11'd2047, 11'd2047);
        send_round(8'd1, 11'd0, 11'd20);
        send_round(8'd1, 11'd0, 11'd14);
        send_round(8'd1, 11'd6, 11'd20);
        send_round(8'd1, 11'd20, 11'd20);
        send_round(8'd1, 11'd10, 11'd20);
        send_round(8'd1, 11'd14, 11'd14);
        send_round(8'd2, 11'd30, 11'd15);
        send_round(8'd2, 11'd1024, 11'd1024);
        send_round(8'd3, 11'd13, 11'd13);
        send_round(8'd3, 11'd0, 11'd0);
        send_round(8'd4, 11'd2047, 11'd0);
        send_round(8'd128, 11'd0, 11'd1024);
        run_phase(16, 4, 200, 10, 6);

        apply_settings(11'd1024, 11'd1024, 11'd1);
        run_phase(32, 8, 150, 15, 20);

        apply_settings(11'd1, 11'd1, 11'd255);
        run_phase(48, 1, 260, 0, 0);
        run_phase(0, SLOTS, 40, 100, 0);

        // committee above the cap, threshold zero, decide on the first round
        apply_settings(11'd2047, 11'd0, 11'd0);
        run_phase(64, 16, 80, 20, 10);

        apply_settings(11'd20, 11'd2047, 11'd0);
        run_phase(96, 8, 60, 20, 10);

        apply_settings(11'd0, 11'd5, 11'd3);
        run_phase(112, 4, 50, 30, 10);

        apply_settings(11'd20, 11'd11, 11'd5);
        run_phase(128, 16, 260, 10, 8);

        s_tvalid <= 1'b0;
        waited = 0;
        do
        begin
            @(posedge clk);
            waited++;
        end
        while (outstanding != 0 && waited < 5000);
        repeat (10) @(posedge clk);

        $display("Covered %0d rounds under %0d register settings with idle, stall and hold-off",
                 rounds_seen, settings_used);
        $display("Results carried %0d accept and %0d reject verdicts; %0d left pending",
                 accepts_seen, rejects_seen, outstanding);
        if (failures == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
